[rtl/core/tdc_pkg.sv]
// Package for the track disk controller core: sizes, codes and the result word type.
// Used by track_disk_controller_core; depends on nothing else.
package tdc_pkg;

    localparam int UNITS             = 2;
    localparam int UNIT_W            = 1;
    localparam int SECTORS_PER_TRACK = 16;
    localparam int SECTOR_W          = 4;
    localparam int MAX_TRACKS        = 1024;
    localparam int TRACK_W           = 11;
    localparam int HEAD_W            = 10;
    localparam int ARG_W             = 16;
    localparam int INDEX_W           = 14;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_STATUS  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    localparam logic [2:0] OP_SEEK   = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_TRACKS = 3'd3;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_BUSY    = 2'd1;
    localparam logic [1:0] RC_INVALID = 2'd2;

    localparam logic [1:0] REG_TRACKS_UNIT_ZERO = 2'd0;
    localparam logic [1:0] REG_TRACKS_UNIT_ONE  = 2'd1;

    // Reciprocal of ten scaled by 2^19; exact for dividends below 43690.
    localparam logic [16:0] RECIP_TEN = 17'd52429;
    localparam int          RECIP_SH  = 19;

    typedef struct packed {
        logic [1:0]         return_code;
        logic [1:0]         unit_status;
        logic [UNITS-1:0]   irq_mask;
        logic               access_valid;
        logic               access_write;
        logic [UNIT_W-1:0]  access_unit;
        logic [INDEX_W-1:0] sector_index;
        logic [TRACK_W-1:0] track_report;
        logic               track_report_valid;
    } result_t;

endpackage

[rtl/core/track_disk_controller_core.sv]
// Track disk controller core: per-unit state, request/status/tick handling.
// Depends on tdc_pkg for sizes, codes and the result word type.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    cmd, unit_sel, operation, argument
//   result    out        out_valid / out_stall  return_code .. track_report_valid
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input word produces exactly one registered result word; a new word can be
// taken every cycle while in_stall is low. The per-unit registers are read and
// written in the same cycle, which allows that rate. A two-entry output buffer
// (result register plus skid register) holds results under out_stall; in_stall
// rises only when both are full. Reset clears all unit state and both track counts.
module track_disk_controller_core
    import tdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic signed [2:0]        unit_sel,
    input  logic [2:0]               operation,
    input  logic signed [ARG_W-1:0]  argument,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               return_code,
    output logic [1:0]               unit_status,
    output logic [UNITS-1:0]         irq_mask,
    output logic                     access_valid,
    output logic                     access_write,
    output logic [UNIT_W-1:0]        access_unit,
    output logic [INDEX_W-1:0]       sector_index,
    output logic [TRACK_W-1:0]       track_report,
    output logic                     track_report_valid,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [TRACK_W-1:0]       cfg_data
);

    logic [TRACK_W-1:0] tracks_reg  [UNITS];
    logic [1:0]         state_reg   [UNITS];
    logic [1:0]         state_next  [UNITS];
    logic [HEAD_W-1:0]  head_reg    [UNITS];
    logic [HEAD_W-1:0]  head_next   [UNITS];
    logic [2:0]         pend_op_reg [UNITS];
    logic [2:0]         pend_op_next[UNITS];
    logic [ARG_W-1:0]   pend_arg_reg [UNITS];
    logic [ARG_W-1:0]   pend_arg_next[UNITS];
    logic [1:0]         ticks_reg   [UNITS];
    logic [1:0]         ticks_next  [UNITS];

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    result_t res;

    logic               accept;
    logic               out_take;
    logic [UNIT_W-1:0]  sel;
    logic               sel_ok;
    logic [16:0]        head_ext;
    logic [16:0]        arg_ext;
    logic [16:0]        diff;
    logic [33:0]        quot_prod;
    logic [14:0]        quot;
    logic [16:0]        quot_ten;
    logic [3:0]         rem;
    logic [1:0]         countdown;
    logic [TRACK_W-1:0] cfg_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign sel    = unit_sel[UNIT_W-1:0];
    assign sel_ok = (unit_sel[2:1] == 2'b00) && (tracks_reg[sel] != '0);

    // Seek countdown: 1 + (|head - target| mod 10), capped at 3.
    assign head_ext  = {7'd0, head_reg[sel]};
    assign arg_ext   = {argument[ARG_W-1], argument};
    assign diff      = ($signed(head_ext) >= $signed(arg_ext)) ? (head_ext - arg_ext)
                                                               : (arg_ext - head_ext);
    assign quot_prod = {17'd0, diff} * {17'd0, RECIP_TEN};
    assign quot      = quot_prod[33:RECIP_SH];
    assign quot_ten  = {quot[13:0], 3'b000} + {1'b0, quot, 1'b0};
    assign rem       = 4'(diff - quot_ten);
    assign countdown = (operation != OP_SEEK) ? 2'd1 :
                       (rem == 4'd0)          ? 2'd1 :
                       (rem == 4'd1)          ? 2'd2 : 2'd3;

    assign cfg_sat = (cfg_data > TRACK_W'(MAX_TRACKS)) ? TRACK_W'(MAX_TRACKS) : cfg_data;

    always_comb
    begin
        logic               acc_done;
        logic               trk_done;
        logic signed [ARG_W-1:0] a;
        logic [1:0]         st;

        res      = '0;
        acc_done = 1'b0;
        trk_done = 1'b0;
        a        = '0;
        st       = ST_READY;
        for (int i = 0; i < UNITS; i++)
        begin
            state_next[i]    = state_reg[i];
            head_next[i]     = head_reg[i];
            pend_op_next[i]  = pend_op_reg[i];
            pend_arg_next[i] = pend_arg_reg[i];
            ticks_next[i]    = ticks_reg[i];
        end

        case (cmd)
            CMD_REQUEST:
            begin
                if (!sel_ok)
                begin
                    res.return_code = RC_INVALID;
                end
                else if (state_reg[sel] == ST_BUSY)
                begin
                    res.return_code = RC_BUSY;
                end
                else
                begin
                    res.return_code    = RC_OK;
                    state_next[sel]    = ST_BUSY;
                    pend_op_next[sel]  = operation;
                    pend_arg_next[sel] = argument;
                    ticks_next[sel]    = countdown;
                end
            end
            CMD_STATUS:
            begin
                if (!sel_ok)
                begin
                    res.return_code = RC_INVALID;
                end
                else
                begin
                    res.return_code = RC_OK;
                    res.unit_status = state_reg[sel];
                    if (state_reg[sel] == ST_ERROR)
                        state_next[sel] = ST_READY;
                end
            end
            CMD_TICK:
            begin
                res.return_code = RC_OK;
                // Lower-numbered units win the access and report fields.
                for (int i = 0; i < UNITS; i++)
                begin
                    if (state_reg[i] == ST_BUSY)
                    begin
                        if (ticks_reg[i] > 2'd1)
                        begin
                            ticks_next[i] = ticks_reg[i] - 2'd1;
                        end
                        else
                        begin
                            ticks_next[i] = 2'd0;
                            a  = $signed(pend_arg_reg[i]);
                            st = ST_READY;
                            case (pend_op_reg[i])
                                OP_SEEK:
                                begin
                                    if (a[ARG_W-1] ||
                                        ({1'b0, a[ARG_W-2:0]} >= ARG_W'(tracks_reg[i])))
                                        st = ST_ERROR;
                                    else
                                        head_next[i] = a[HEAD_W-1:0];
                                end
                                OP_READ, OP_WRITE:
                                begin
                                    if (a[ARG_W-1] ||
                                        (a[ARG_W-2:0] >= (ARG_W-1)'(SECTORS_PER_TRACK)))
                                    begin
                                        st = ST_ERROR;
                                    end
                                    else if (!acc_done)
                                    begin
                                        acc_done         = 1'b1;
                                        res.access_valid = 1'b1;
                                        res.access_write = (pend_op_reg[i] == OP_WRITE);
                                        res.access_unit  = UNIT_W'(i);
                                        res.sector_index = {head_reg[i], a[SECTOR_W-1:0]};
                                    end
                                end
                                OP_TRACKS:
                                begin
                                    if (!trk_done)
                                    begin
                                        trk_done               = 1'b1;
                                        res.track_report       = tracks_reg[i];
                                        res.track_report_valid = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    st = ST_ERROR;
                                end
                            endcase
                            state_next[i]  = st;
                            res.irq_mask[i] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < UNITS; i++)
            begin
                tracks_reg[i]   <= '0;
                state_reg[i]    <= ST_READY;
                head_reg[i]     <= '0;
                pend_op_reg[i]  <= '0;
                pend_arg_reg[i] <= '0;
                ticks_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TRACKS_UNIT_ZERO: tracks_reg[0] <= cfg_sat;
                    REG_TRACKS_UNIT_ONE:  tracks_reg[1] <= cfg_sat;
                    default:              ;
                endcase
            end
            if (accept)
            begin
                for (int i = 0; i < UNITS; i++)
                begin
                    state_reg[i]    <= state_next[i];
                    head_reg[i]     <= head_next[i];
                    pend_op_reg[i]  <= pend_op_next[i];
                    pend_arg_reg[i] <= pend_arg_next[i];
                    ticks_reg[i]    <= ticks_next[i];
                end
            end
        end
    end

    // Result register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign return_code        = out_reg.return_code;
    assign unit_status        = out_reg.unit_status;
    assign irq_mask           = out_reg.irq_mask;
    assign access_valid       = out_reg.access_valid;
    assign access_write       = out_reg.access_write;
    assign access_unit        = out_reg.access_unit;
    assign sector_index       = out_reg.sector_index;
    assign track_report       = out_reg.track_report;
    assign track_report_valid = out_reg.track_report_valid;

endmodule
